[rtl/lts_pkg.sv]
// lap telemetry statistics: shared constants, types and a helper function
// used by the controller, datapath and divider lanes; no dependencies
`default_nettype none

package lts_pkg;

    localparam int MaxSamples = 65536;
    localparam int TickMs     = 16;

    localparam int SpeedW = 17;
    localparam int PedalW = 13;
    localparam int GW     = 14;
    localparam int DistW  = 24;
    localparam int TimeW  = 21;
    localparam int CfgW   = 13;

    localparam int CountW    = $clog2(MaxSamples + 1);
    localparam int TickW     = $clog2(TickMs + 1);
    localparam int SpeedSumW = SpeedW + CountW;
    localparam int PedalSumW = PedalW + CountW;
    localparam int DivW      = SpeedSumW;
    localparam int StepW     = $clog2(DivW);
    localparam int ProdW     = CountW + TickW;
    localparam int TimeCalcW = (ProdW > TimeW) ? ProdW : TimeW + 1;

    localparam logic [SpeedW-1:0] NoCornerSpeed = SpeedW'(100000);
    localparam logic [TimeW-1:0]  TimeMax       = {TimeW{1'b1}};
    localparam logic [CountW-1:0] CountLimit    = CountW'(MaxSamples);

    localparam logic CfgCornerIdx = 1'b0;
    localparam logic CfgPedalIdx  = 1'b1;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } lts_cmd_t;

    function automatic logic [TimeW-1:0] time_of(input logic [CountW-1:0] count);
        logic [TimeCalcW-1:0] prod;
        prod = TimeCalcW'(count) * TimeCalcW'(TickMs);
        if (prod > TimeCalcW'(TimeMax))
            time_of = TimeMax;
        else
            time_of = prod[TimeW-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/lts_div.sv]
// lap telemetry statistics: one restoring divider lane, one quotient bit per step
// depends on lts_pkg
`default_nettype none

module lts_div (
    input  wire logic                       clk,
    input  wire logic                       start,
    input  wire logic                       step,
    input  wire logic [lts_pkg::DivW-1:0]   dividend,
    input  wire logic [lts_pkg::CountW-1:0] divisor,
    output logic      [lts_pkg::DivW-1:0]   quotient
);

    logic [lts_pkg::DivW-1:0]   quo_reg, quo_next;
    logic [lts_pkg::CountW-1:0] rem_reg, rem_next;
    logic [lts_pkg::CountW:0]   trial;
    logic [lts_pkg::CountW:0]   diff;
    logic                       ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[lts_pkg::DivW-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
        end
        else if (step)
        begin
            quo_next = {quo_reg[lts_pkg::DivW-2:0], ge};
            rem_next = ge ? diff[lts_pkg::CountW-1:0] : trial[lts_pkg::CountW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/lts_ctrl.sv]
// lap telemetry statistics: controller for sample intake, end-of-lap division
// and output word handoff; depends on lts_pkg
`default_nettype none

module lts_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          last_sample,
    input  wire logic          out_ready,
    output logic               in_ready,
    output logic               out_valid,
    output lts_pkg::lts_cmd_t  cmd
);

    localparam logic [1:0] StAcc  = 2'd0;
    localparam logic [1:0] StDiv  = 2'd1;
    localparam logic [1:0] StDone = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [lts_pkg::StepW-1:0] step_reg, step_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      in_fire;

    always_comb
    begin
        in_ready       = (state_reg == StAcc);
        in_fire        = in_valid && in_ready;
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.accept     = in_fire;
        cmd.div_step   = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            StAcc:
            begin
                if (in_fire && last_sample)
                begin
                    state_next = StDiv;
                    step_next  = '0;
                end
            end
            StDiv:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == lts_pkg::StepW'(lts_pkg::DivW - 1))
                    state_next = StDone;
            end
            StDone:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = StAcc;
                end
            end
            default:
            begin
                state_next = StAcc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StAcc;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/lts_datapath.sv]
// lap telemetry statistics: lap accumulators, peaks, result bank, divider lanes
// and output register; depends on lts_pkg and lts_div
`default_nettype none

module lts_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lts_pkg::lts_cmd_t                 cmd,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic        [lts_pkg::CfgW-1:0]   cfg_data,
    input  wire logic        [lts_pkg::SpeedW-1:0] speed,
    input  wire logic        [lts_pkg::PedalW-1:0] throttle,
    input  wire logic        [lts_pkg::PedalW-1:0] brake,
    input  wire logic signed [lts_pkg::GW-1:0]     lateral_g,
    input  wire logic signed [lts_pkg::GW-1:0]     longitudinal_g,
    input  wire logic        [lts_pkg::DistW-1:0]  lap_distance,
    input  wire logic                              last_sample,
    output logic             [lts_pkg::SpeedW-1:0] max_speed,
    output logic             [lts_pkg::DistW-1:0]  top_speed_distance,
    output logic             [lts_pkg::GW-1:0]     max_lateral_g,
    output logic             [lts_pkg::GW-2:0]     max_accel_g,
    output logic signed      [lts_pkg::GW-1:0]     max_braking_g,
    output logic             [lts_pkg::SpeedW-1:0] min_corner_speed,
    output logic             [lts_pkg::SpeedW-1:0] avg_speed,
    output logic             [lts_pkg::PedalW-1:0] avg_throttle,
    output logic             [lts_pkg::PedalW-1:0] avg_brake,
    output logic             [lts_pkg::TimeW-1:0]  throttle_ms,
    output logic             [lts_pkg::TimeW-1:0]  brake_ms,
    output logic             [lts_pkg::TimeW-1:0]  coast_ms
);

    // configuration
    logic [lts_pkg::CfgW-1:0] corner_thr_reg;
    logic [lts_pkg::CfgW-1:0] pedal_thr_reg;

    // lap state
    logic        [lts_pkg::SpeedSumW-1:0] speed_sum_reg, speed_sum_next;
    logic        [lts_pkg::PedalSumW-1:0] throttle_sum_reg, throttle_sum_next;
    logic        [lts_pkg::PedalSumW-1:0] brake_sum_reg, brake_sum_next;
    logic        [lts_pkg::CountW-1:0]    count_reg, count_next;
    logic        [lts_pkg::SpeedW-1:0]    peak_speed_reg, peak_speed_next;
    logic        [lts_pkg::DistW-1:0]     peak_dist_reg, peak_dist_next;
    logic        [lts_pkg::GW-1:0]        peak_lat_reg, peak_lat_next;
    logic signed [lts_pkg::GW-1:0]        peak_accel_reg, peak_accel_next;
    logic signed [lts_pkg::GW-1:0]        peak_brk_reg, peak_brk_next;
    logic        [lts_pkg::SpeedW-1:0]    low_corner_reg, low_corner_next;
    logic        [lts_pkg::CountW-1:0]    thr_cnt_reg, thr_cnt_next;
    logic        [lts_pkg::CountW-1:0]    brk_cnt_reg, brk_cnt_next;
    logic        [lts_pkg::CountW-1:0]    cst_cnt_reg, cst_cnt_next;

    // finished lap waiting for its averages
    logic        [lts_pkg::SpeedW-1:0] res_speed_reg;
    logic        [lts_pkg::DistW-1:0]  res_dist_reg;
    logic        [lts_pkg::GW-1:0]     res_lat_reg;
    logic        [lts_pkg::GW-2:0]     res_accel_reg;
    logic signed [lts_pkg::GW-1:0]     res_brk_reg;
    logic        [lts_pkg::SpeedW-1:0] res_corner_reg;
    logic        [lts_pkg::TimeW-1:0]  res_thr_ms_reg;
    logic        [lts_pkg::TimeW-1:0]  res_brk_ms_reg;
    logic        [lts_pkg::TimeW-1:0]  res_cst_ms_reg;
    logic        [lts_pkg::CountW-1:0] div_n_reg;

    logic [lts_pkg::GW-1:0]   abs_lat;
    logic                     counting;
    logic                     start_div;
    logic [lts_pkg::DivW-1:0] q_speed, q_throttle, q_brake;

    always_comb
    begin
        abs_lat  = lateral_g[lts_pkg::GW-1] ? (~lateral_g + 1'b1) : lateral_g;
        counting = (count_reg < lts_pkg::CountLimit);

        speed_sum_next    = speed_sum_reg;
        throttle_sum_next = throttle_sum_reg;
        brake_sum_next    = brake_sum_reg;
        count_next        = count_reg;
        thr_cnt_next      = thr_cnt_reg;
        brk_cnt_next      = brk_cnt_reg;
        cst_cnt_next      = cst_cnt_reg;
        if (counting)
        begin
            speed_sum_next    = speed_sum_reg + lts_pkg::SpeedSumW'(speed);
            throttle_sum_next = throttle_sum_reg + lts_pkg::PedalSumW'(throttle);
            brake_sum_next    = brake_sum_reg + lts_pkg::PedalSumW'(brake);
            count_next        = count_reg + 1'b1;
            priority if (throttle > pedal_thr_reg)
                thr_cnt_next = thr_cnt_reg + 1'b1;
            else if (brake > pedal_thr_reg)
                brk_cnt_next = brk_cnt_reg + 1'b1;
            else
                cst_cnt_next = cst_cnt_reg + 1'b1;
        end

        peak_speed_next = peak_speed_reg;
        peak_dist_next  = peak_dist_reg;
        if (speed > peak_speed_reg)
        begin
            peak_speed_next = speed;
            peak_dist_next  = lap_distance;
        end
        peak_lat_next   = (abs_lat > peak_lat_reg) ? abs_lat : peak_lat_reg;
        peak_accel_next = (longitudinal_g > peak_accel_reg) ? longitudinal_g : peak_accel_reg;
        peak_brk_next   = (longitudinal_g < peak_brk_reg) ? longitudinal_g : peak_brk_reg;
        low_corner_next = low_corner_reg;
        if ((abs_lat > lts_pkg::GW'(corner_thr_reg)) && (speed < low_corner_reg))
            low_corner_next = speed;

        start_div = cmd.accept && last_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_thr_reg <= lts_pkg::CfgW'(512);
            pedal_thr_reg  <= lts_pkg::CfgW'(410);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lts_pkg::CfgCornerIdx: corner_thr_reg <= cfg_data;
                lts_pkg::CfgPedalIdx:  pedal_thr_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_sum_reg    <= '0;
            throttle_sum_reg <= '0;
            brake_sum_reg    <= '0;
            count_reg        <= '0;
            peak_speed_reg   <= '0;
            peak_dist_reg    <= '0;
            peak_lat_reg     <= '0;
            peak_accel_reg   <= '0;
            peak_brk_reg     <= '0;
            low_corner_reg   <= lts_pkg::NoCornerSpeed;
            thr_cnt_reg      <= '0;
            brk_cnt_reg      <= '0;
            cst_cnt_reg      <= '0;
        end
        else if (cmd.accept)
        begin
            if (last_sample)
            begin
                speed_sum_reg    <= '0;
                throttle_sum_reg <= '0;
                brake_sum_reg    <= '0;
                count_reg        <= '0;
                peak_speed_reg   <= '0;
                peak_dist_reg    <= '0;
                peak_lat_reg     <= '0;
                peak_accel_reg   <= '0;
                peak_brk_reg     <= '0;
                low_corner_reg   <= lts_pkg::NoCornerSpeed;
                thr_cnt_reg      <= '0;
                brk_cnt_reg      <= '0;
                cst_cnt_reg      <= '0;
            end
            else
            begin
                speed_sum_reg    <= speed_sum_next;
                throttle_sum_reg <= throttle_sum_next;
                brake_sum_reg    <= brake_sum_next;
                count_reg        <= count_next;
                peak_speed_reg   <= peak_speed_next;
                peak_dist_reg    <= peak_dist_next;
                peak_lat_reg     <= peak_lat_next;
                peak_accel_reg   <= peak_accel_next;
                peak_brk_reg     <= peak_brk_next;
                low_corner_reg   <= low_corner_next;
                thr_cnt_reg      <= thr_cnt_next;
                brk_cnt_reg      <= brk_cnt_next;
                cst_cnt_reg      <= cst_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_div)
        begin
            res_speed_reg  <= peak_speed_next;
            res_dist_reg   <= peak_dist_next;
            res_lat_reg    <= peak_lat_next;
            res_accel_reg  <= peak_accel_next[lts_pkg::GW-2:0];
            res_brk_reg    <= peak_brk_next;
            res_corner_reg <= low_corner_next;
            res_thr_ms_reg <= lts_pkg::time_of(thr_cnt_next);
            res_brk_ms_reg <= lts_pkg::time_of(brk_cnt_next);
            res_cst_ms_reg <= lts_pkg::time_of(cst_cnt_next);
            div_n_reg      <= count_next;
        end
    end

    lts_div u_div_speed (
        .clk      (clk),
        .start    (start_div),
        .step     (cmd.div_step),
        .dividend (lts_pkg::DivW'(speed_sum_next)),
        .divisor  (div_n_reg),
        .quotient (q_speed)
    );

    lts_div u_div_throttle (
        .clk      (clk),
        .start    (start_div),
        .step     (cmd.div_step),
        .dividend (lts_pkg::DivW'(throttle_sum_next)),
        .divisor  (start_div ? count_next : div_n_reg),
        .quotient (q_throttle)
    );

    lts_div u_div_brake (
        .clk      (clk),
        .start    (start_div),
        .step     (cmd.div_step),
        .dividend (lts_pkg::DivW'(brake_sum_next)),
        .divisor  (div_n_reg),
        .quotient (q_brake)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            max_speed          <= res_speed_reg;
            top_speed_distance <= res_dist_reg;
            max_lateral_g      <= res_lat_reg;
            max_accel_g        <= res_accel_reg;
            max_braking_g      <= res_brk_reg;
            min_corner_speed   <= res_corner_reg;
            avg_speed          <= q_speed[lts_pkg::SpeedW-1:0];
            avg_throttle       <= q_throttle[lts_pkg::PedalW-1:0];
            avg_brake          <= q_brake[lts_pkg::PedalW-1:0];
            throttle_ms        <= res_thr_ms_reg;
            brake_ms           <= res_brk_ms_reg;
            coast_ms           <= res_cst_ms_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/lap_telemetry_statistics_unit.sv]
// lap telemetry statistics: top level joining controller and datapath
// depends on lts_pkg, lts_ctrl, lts_datapath
//
// usage:
//   input channel in_valid/in_ready carries one telemetry sample per word;
//   samples are taken one per cycle while a lap is being gathered
//   a word with last_sample set closes the lap: its statistics come out as
//   one result word on out_valid/out_ready; other samples give no result
//   after a last sample in_ready stays low while three restoring divider
//   lanes form the three averages one quotient bit per cycle, and until the
//   result has moved into the output register
//   throughput: one sample per cycle within a lap, none during a lap end
//   if the receiver stalls, the result waits in the output register and
//   samples of the next lap are still taken; a second lap end is taken too,
//   but its result and further intake wait until the output register frees up
//   reset clears all lap state and the output valid, and sets the
//   thresholds to 512 (cornering) and 410 (pedal)
//   cfg_we writes cfg_data to register cfg_index (0 corner, 1 pedal);
//   write only while no lap end is in flight
`default_nettype none

module lap_telemetry_statistics_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic        [lts_pkg::CfgW-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic        [lts_pkg::SpeedW-1:0] speed,
    input  wire logic        [lts_pkg::PedalW-1:0] throttle,
    input  wire logic        [lts_pkg::PedalW-1:0] brake,
    input  wire logic signed [lts_pkg::GW-1:0]     lateral_g,
    input  wire logic signed [lts_pkg::GW-1:0]     longitudinal_g,
    input  wire logic        [lts_pkg::DistW-1:0]  lap_distance,
    input  wire logic                              last_sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic             [lts_pkg::SpeedW-1:0] max_speed,
    output logic             [lts_pkg::DistW-1:0]  top_speed_distance,
    output logic             [lts_pkg::GW-1:0]     max_lateral_g,
    output logic             [lts_pkg::GW-2:0]     max_accel_g,
    output logic signed      [lts_pkg::GW-1:0]     max_braking_g,
    output logic             [lts_pkg::SpeedW-1:0] min_corner_speed,
    output logic             [lts_pkg::SpeedW-1:0] avg_speed,
    output logic             [lts_pkg::PedalW-1:0] avg_throttle,
    output logic             [lts_pkg::PedalW-1:0] avg_brake,
    output logic             [lts_pkg::TimeW-1:0]  throttle_ms,
    output logic             [lts_pkg::TimeW-1:0]  brake_ms,
    output logic             [lts_pkg::TimeW-1:0]  coast_ms
);

    lts_pkg::lts_cmd_t cmd;

    lts_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_sample (last_sample),
        .out_ready   (out_ready),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .cmd         (cmd)
    );

    lts_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .speed              (speed),
        .throttle           (throttle),
        .brake              (brake),
        .lateral_g          (lateral_g),
        .longitudinal_g     (longitudinal_g),
        .lap_distance       (lap_distance),
        .last_sample        (last_sample),
        .max_speed          (max_speed),
        .top_speed_distance (top_speed_distance),
        .max_lateral_g      (max_lateral_g),
        .max_accel_g        (max_accel_g),
        .max_braking_g      (max_braking_g),
        .min_corner_speed   (min_corner_speed),
        .avg_speed          (avg_speed),
        .avg_throttle       (avg_throttle),
        .avg_brake          (avg_brake),
        .throttle_ms        (throttle_ms),
        .brake_ms           (brake_ms),
        .coast_ms           (coast_ms)
    );

endmodule

`default_nettype wire

[rtl/lts_checker.sv]
// lap telemetry statistics: port-level checker and its bind to the top level
// depends on lts_pkg
`default_nettype none

module lts_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              last_sample,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic        [lts_pkg::SpeedW-1:0] max_speed,
    input wire logic signed [lts_pkg::GW-1:0]     max_braking_g,
    input wire logic        [lts_pkg::SpeedW-1:0] min_corner_speed
);

    // lap end stops intake while the averages are formed
    a_lap_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_sample) |=> !in_ready)
        else $error("in_ready high right after a lap end");

    // no result appears in the cycle after a lap end
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_sample && !out_valid) |=> !out_valid)
        else $error("result shown before averages done");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(max_speed)))
        else $error("stalled result word changed");

    a_braking_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_braking_g[lts_pkg::GW-1] || (max_braking_g == '0)))
        else $error("braking peak above zero");

    a_corner_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_corner_speed <= lts_pkg::NoCornerSpeed))
        else $error("corner speed above no-corner value");

endmodule

bind lap_telemetry_statistics_unit lts_checker u_lts_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .last_sample      (last_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .max_speed        (max_speed),
    .max_braking_g    (max_braking_g),
    .min_corner_speed (min_corner_speed)
);

`default_nettype wire

[test/tb_lap_telemetry_statistics_unit.sv]
// testbench for lap_telemetry_statistics_unit: a directed table, then random
// laps under several threshold settings
// depends on rtl/lts_pkg.sv and the unit's rtl; checks every result word itself
`default_nettype none

module tb_lap_telemetry_statistics_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lts_pkg::*;

    localparam int DrainCycles = 40;
    localparam int QuietLimit  = 2000;
    localparam int PhaseItems  = 200;
    localparam int ReportMax   = 10;

    typedef struct {
        logic [SpeedW-1:0]    speed;
        logic [PedalW-1:0]    throttle;
        logic [PedalW-1:0]    brake;
        logic signed [GW-1:0] lat;
        logic signed [GW-1:0] lon;
        logic [DistW-1:0]     lap_dist;
        logic                 is_last;
    } sample_t;

    typedef struct {
        logic [SpeedW-1:0]    max_speed;
        logic [DistW-1:0]     top_dist;
        logic [GW-1:0]        max_lat;
        logic [GW-2:0]        max_accel;
        logic signed [GW-1:0] max_brake;
        logic [SpeedW-1:0]    min_corner;
        logic [SpeedW-1:0]    avg_speed;
        logic [PedalW-1:0]    avg_throttle;
        logic [PedalW-1:0]    avg_brake;
        logic [TimeW-1:0]     throttle_ms;
        logic [TimeW-1:0]     brake_ms;
        logic [TimeW-1:0]     coast_ms;
    } lap_stats_t;

    typedef logic [DistW-1:0] stat_vec_t [12];

    string stat_names [12] = '{"max_speed", "top_speed_distance", "max_lateral_g",
                               "max_accel_g", "max_braking_g", "min_corner_speed",
                               "avg_speed", "avg_throttle", "avg_brake",
                               "throttle_ms", "brake_ms", "coast_ms"};

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_we         = 1'b0;
    logic                 cfg_index      = CfgCornerIdx;
    logic [CfgW-1:0]      cfg_data       = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [SpeedW-1:0]    speed          = '0;
    logic [PedalW-1:0]    throttle       = '0;
    logic [PedalW-1:0]    brake          = '0;
    logic signed [GW-1:0] lateral_g      = '0;
    logic signed [GW-1:0] longitudinal_g = '0;
    logic [DistW-1:0]     lap_distance   = '0;
    logic                 last_sample    = 1'b0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic [SpeedW-1:0]    max_speed;
    logic [DistW-1:0]     top_speed_distance;
    logic [GW-1:0]        max_lateral_g;
    logic [GW-2:0]        max_accel_g;
    logic signed [GW-1:0] max_braking_g;
    logic [SpeedW-1:0]    min_corner_speed;
    logic [SpeedW-1:0]    avg_speed;
    logic [PedalW-1:0]    avg_throttle;
    logic [PedalW-1:0]    avg_brake;
    logic [TimeW-1:0]     throttle_ms;
    logic [TimeW-1:0]     brake_ms;
    logic [TimeW-1:0]     coast_ms;

    lap_telemetry_statistics_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .speed              (speed),
        .throttle           (throttle),
        .brake              (brake),
        .lateral_g          (lateral_g),
        .longitudinal_g     (longitudinal_g),
        .lap_distance       (lap_distance),
        .last_sample        (last_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .max_speed          (max_speed),
        .top_speed_distance (top_speed_distance),
        .max_lateral_g      (max_lateral_g),
        .max_accel_g        (max_accel_g),
        .max_braking_g      (max_braking_g),
        .min_corner_speed   (min_corner_speed),
        .avg_speed          (avg_speed),
        .avg_throttle       (avg_throttle),
        .avg_brake          (avg_brake),
        .throttle_ms        (throttle_ms),
        .brake_ms           (brake_ms),
        .coast_ms           (coast_ms)
    );

    // lap statistics predictor state
    logic [CfgW-1:0]      corner_thr;
    logic [CfgW-1:0]      pedal_thr;
    logic [SpeedSumW-1:0] speed_acc;
    logic [PedalSumW-1:0] throttle_acc;
    logic [PedalSumW-1:0] brake_acc;
    logic [CountW-1:0]    n_samples;
    logic [CountW-1:0]    n_throttle;
    logic [CountW-1:0]    n_brake;
    logic [CountW-1:0]    n_coast;
    logic [SpeedW-1:0]    top_speed;
    logic [DistW-1:0]     top_speed_at;
    logic [SpeedW-1:0]    slowest_corner;
    logic [GW-1:0]        top_lat;
    logic signed [GW-1:0] top_accel;
    logic signed [GW-1:0] top_brake;

    lap_stats_t pending_laps [$];
    sample_t    plan_samples [$];
    bit         plan_typed [$];
    lap_stats_t plan_want [$];

    bit calm          = 1'b0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int samples_sent  = 0;
    int laps_checked  = 0;
    int mismatches    = 0;
    int settings_used = 1;

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic clear_lap_totals();
        speed_acc      = '0;
        throttle_acc   = '0;
        brake_acc      = '0;
        n_samples      = '0;
        n_throttle     = '0;
        n_brake        = '0;
        n_coast        = '0;
        top_speed      = '0;
        top_speed_at   = '0;
        slowest_corner = NoCornerSpeed;
        top_lat        = '0;
        top_accel      = '0;
        top_brake      = '0;
    endtask

    function automatic logic [TimeW-1:0] ticks_to_ms(input logic [CountW-1:0] n);
        logic [31:0] t;
        t = 32'(n) * 32'(TickMs);
        return (t > 32'(TimeMax)) ? TimeMax : t[TimeW-1:0];
    endfunction

    task automatic absorb_sample(input sample_t s, output bit closed, output lap_stats_t r);
        logic [GW-1:0] alat;
        alat = s.lat[GW-1] ? (~s.lat + 1'b1) : s.lat;
        // past the sample limit only the peaks and the corner minimum move
        if (n_samples < CountW'(MaxSamples))
        begin
            speed_acc    += SpeedSumW'(s.speed);
            throttle_acc += PedalSumW'(s.throttle);
            brake_acc    += PedalSumW'(s.brake);
            n_samples++;
            if (s.throttle > pedal_thr)
                n_throttle++;
            else if (s.brake > pedal_thr)
                n_brake++;
            else
                n_coast++;
        end
        if (s.speed > top_speed)
        begin
            top_speed    = s.speed;
            top_speed_at = s.lap_dist;
        end
        if (alat > top_lat)
            top_lat = alat;
        if (s.lon > top_accel)
            top_accel = s.lon;
        if (s.lon < top_brake)
            top_brake = s.lon;
        if (alat > corner_thr && s.speed < slowest_corner)
            slowest_corner = s.speed;
        closed = s.is_last;
        r = '{default: '0};
        if (closed)
        begin
            r.max_speed    = top_speed;
            r.top_dist     = top_speed_at;
            r.max_lat      = top_lat;
            r.max_accel    = top_accel[GW-2:0];
            r.max_brake    = top_brake;
            r.min_corner   = slowest_corner;
            r.avg_speed    = SpeedW'(speed_acc / SpeedSumW'(n_samples));
            r.avg_throttle = PedalW'(throttle_acc / PedalSumW'(n_samples));
            r.avg_brake    = PedalW'(brake_acc / PedalSumW'(n_samples));
            r.throttle_ms  = ticks_to_ms(n_throttle);
            r.brake_ms     = ticks_to_ms(n_brake);
            r.coast_ms     = ticks_to_ms(n_coast);
            clear_lap_totals();
        end
    endtask

    function automatic sample_t mk_sample(input int sp, input int thr, input int brk,
                                          input int lat, input int lon, input int lap_pos,
                                          input bit is_last);
        sample_t s;
        s.speed    = SpeedW'(sp);
        s.throttle = PedalW'(thr);
        s.brake    = PedalW'(brk);
        s.lat      = GW'(lat);
        s.lon      = GW'(lon);
        s.lap_dist = DistW'(lap_pos);
        s.is_last  = is_last;
        return s;
    endfunction

    function automatic lap_stats_t mk_stats(input int ms, input int top_pos, input int lat,
                                            input int acc, input int brk, input int corner,
                                            input int avs, input int avt, input int avb,
                                            input int tms, input int bms, input int cms);
        lap_stats_t r;
        r.max_speed    = SpeedW'(ms);
        r.top_dist     = DistW'(top_pos);
        r.max_lat      = GW'(lat);
        r.max_accel    = (GW-1)'(acc);
        r.max_brake    = GW'(brk);
        r.min_corner   = SpeedW'(corner);
        r.avg_speed    = SpeedW'(avs);
        r.avg_throttle = PedalW'(avt);
        r.avg_brake    = PedalW'(avb);
        r.throttle_ms  = TimeW'(tms);
        r.brake_ms     = TimeW'(bms);
        r.coast_ms     = TimeW'(cms);
        return r;
    endfunction

    task automatic add_row(input sample_t s, input bit typed, input lap_stats_t want);
        plan_samples.push_back(s);
        plan_typed.push_back(typed);
        plan_want.push_back(want);
    endtask

    task automatic load_plan();
        lap_stats_t none;
        none = '{default: '0};
        // one-sample laps at the field extremes and the pedal thresholds
        add_row(mk_sample(0, 0, 0, 0, 0, 0, 1), 1'b1,
                mk_stats(0, 0, 0, 0, 0, 100000, 0, 0, 0, 0, 0, 16));
        add_row(mk_sample(100000, 4096, 0, 8191, 8191, 16777215, 1), 1'b1,
                mk_stats(100000, 16777215, 8191, 8191, 0, 100000, 100000, 4096, 0, 16, 0, 0));
        add_row(mk_sample(131071, 0, 8191, -8192, -8192, 0, 1), 1'b1,
                mk_stats(131071, 0, 8192, 0, -8192, 100000, 131071, 0, 8191, 0, 16, 0));
        add_row(mk_sample(5000, 410, 411, 600, 0, 77, 1), 1'b1,
                mk_stats(5000, 77, 600, 0, 0, 5000, 5000, 410, 411, 0, 16, 0));
        // speed ties, lateral exactly at and just past the threshold
        add_row(mk_sample(3000, 411, 4096, 512, 100, 10, 0), 1'b0, none);
        add_row(mk_sample(3000, 0, 0, -513, -100, 20, 0), 1'b0, none);
        add_row(mk_sample(2000, 4096, 0, 513, 8191, 30, 0), 1'b0, none);
        add_row(mk_sample(2500, 410, 410, -8192, -8192, 40, 0), 1'b0, none);
        add_row(mk_sample(3000, 411, 411, 0, 0, 50, 1), 1'b0, none);
        add_row(mk_sample(60000, 8191, 8191, -512, -1, 100, 0), 1'b0, none);
        add_row(mk_sample(40000, 0, 8191, 1000, 1, 200, 0), 1'b0, none);
        add_row(mk_sample(40000, 0, 0, -1000, 0, 300, 0), 1'b0, none);
        add_row(mk_sample(70000, 100, 0, 8191, 2, 400, 0), 1'b0, none);
        add_row(mk_sample(10, 4096, 4096, -600, -2, 500, 1), 1'b0, none);
        add_row(mk_sample(131071, 0, 0, 0, 0, 600, 0), 1'b0, none);
        add_row(mk_sample(131071, 0, 0, 0, 0, 700, 1), 1'b0, none);
    endtask

    function automatic logic [PedalW-1:0] random_pedal();
        case ($urandom_range(0, 5))
            0: return PedalW'($urandom);
            1: return ($urandom_range(0, 1) == 0) ? PedalW'(0) : PedalW'(4096);
            2: return PedalW'(int'(pedal_thr) + $urandom_range(0, 2) - 1);
            default: return PedalW'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic logic signed [GW-1:0] random_g();
        int v;
        case ($urandom_range(0, 5))
            0: return GW'($urandom);
            1:
            begin
                case ($urandom_range(0, 2))
                    0: v = -8192;
                    1: v = 8191;
                    default: v = 0;
                endcase
                return GW'(v);
            end
            2:
            begin
                v = int'(corner_thr) + $urandom_range(0, 2) - 1;
                return ($urandom_range(0, 1) == 0) ? GW'(v) : GW'(-v);
            end
            default: return GW'(int'($urandom_range(0, 6000)) - 3000);
        endcase
    endfunction

    function automatic sample_t random_sample(input bit closing);
        sample_t s;
        case ($urandom_range(0, 7))
            0: s.speed = SpeedW'($urandom);
            1:
            begin
                case ($urandom_range(0, 2))
                    0: s.speed = '0;
                    1: s.speed = SpeedW'(100000);
                    default: s.speed = '1;
                endcase
            end
            2: s.speed = SpeedW'($urandom_range(9000, 9002));
            default: s.speed = SpeedW'($urandom_range(0, 100000));
        endcase
        s.throttle = random_pedal();
        s.brake    = random_pedal();
        s.lat      = random_g();
        s.lon      = random_g();
        s.lap_dist = DistW'($urandom);
        s.is_last  = closing;
        return s;
    endfunction

    task automatic send_sample(input sample_t s, input bit typed, input lap_stats_t want);
        bit         closed;
        lap_stats_t predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        speed          <= s.speed;
        throttle       <= s.throttle;
        brake          <= s.brake;
        lateral_g      <= s.lat;
        longitudinal_g <= s.lon;
        lap_distance   <= s.lap_dist;
        last_sample    <= s.is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_sample(s, closed, predicted);
        samples_sent++;
        if (closed)
            pending_laps.push_back(typed ? want : predicted);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_laps.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_thresholds(input logic [CfgW-1:0] corner, input logic [CfgW-1:0] pedal);
        cfg_we    <= 1'b1;
        cfg_index <= CfgCornerIdx;
        cfg_data  <= corner;
        @(posedge clk);
        cfg_index <= CfgPedalIdx;
        cfg_data  <= pedal;
        @(posedge clk);
        cfg_we <= 1'b0;
        corner_thr = corner;
        pedal_thr  = pedal;
        settings_used++;
    endtask

    task automatic run_random_laps(input int items);
        int         sent;
        int         lap_len;
        lap_stats_t none;
        sent = 0;
        none = '{default: '0};
        while (sent < items)
        begin
            lap_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            for (int j = 0; j < lap_len; j++)
                send_sample(random_sample(j == lap_len - 1), 1'b0, none);
            sent += lap_len;
        end
    endtask

    function automatic stat_vec_t to_vec(input lap_stats_t st);
        stat_vec_t v;
        v[0]  = DistW'(st.max_speed);
        v[1]  = st.top_dist;
        v[2]  = DistW'(st.max_lat);
        v[3]  = DistW'(st.max_accel);
        v[4]  = DistW'(st.max_brake);
        v[5]  = DistW'(st.min_corner);
        v[6]  = DistW'(st.avg_speed);
        v[7]  = DistW'(st.avg_throttle);
        v[8]  = DistW'(st.avg_brake);
        v[9]  = DistW'(st.throttle_ms);
        v[10] = DistW'(st.brake_ms);
        v[11] = DistW'(st.coast_ms);
        return v;
    endfunction

    task automatic compare_stats(input lap_stats_t want, input lap_stats_t got);
        stat_vec_t w;
        stat_vec_t g;
        w = to_vec(want);
        g = to_vec(got);
        for (int f = 0; f < 12; f++)
        begin
            if (w[f] !== g[f])
            begin
                if (mismatches < ReportMax)
                    $display("lap %0d %s: expected %h, got %h",
                             laps_checked, stat_names[f], w[f], g[f]);
                mismatches++;
            end
        end
    endtask

    // result word checker
    always @(posedge clk)
    begin
        lap_stats_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.max_speed    = max_speed;
            got.top_dist     = top_speed_distance;
            got.max_lat      = max_lateral_g;
            got.max_accel    = max_accel_g;
            got.max_brake    = max_braking_g;
            got.min_corner   = min_corner_speed;
            got.avg_speed    = avg_speed;
            got.avg_throttle = avg_throttle;
            got.avg_brake    = avg_brake;
            got.throttle_ms  = throttle_ms;
            got.brake_ms     = brake_ms;
            got.coast_ms     = coast_ms;
            if (pending_laps.size() == 0)
            begin
                if (mismatches < ReportMax)
                    $display("result word with no lap pending, max_speed %h", max_speed);
                mismatches++;
            end
            else
            begin
                compare_stats(pending_laps.pop_front(), got);
            end
            laps_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QuietLimit)
            @(posedge clk);
        $display("no handshake for %0d cycles", QuietLimit);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        corner_thr = CfgW'(512);
        pedal_thr  = CfgW'(410);
        clear_lap_totals();
        load_plan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < plan_samples.size(); i++)
            send_sample(plan_samples[i], plan_typed[i], plan_want[i]);
        settle();

        write_thresholds('0, '0);
        run_random_laps(PhaseItems);
        settle();
        write_thresholds('1, CfgW'(4096));
        run_random_laps(PhaseItems);
        settle();
        write_thresholds(CfgW'($urandom_range(0, 8191)), '1);
        run_random_laps(PhaseItems);
        settle();
        write_thresholds(CfgW'($urandom_range(0, 8191)), CfgW'($urandom_range(0, 4096)));
        run_random_laps(PhaseItems / 2);
        calm = 1'b1;
        run_random_laps(PhaseItems / 2);
        settle();

        $display("checked %0d laps from %0d samples under %0d threshold settings",
                 laps_checked, samples_sent, settings_used);
        $display("field extremes, threshold edges and random laps with stalls; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/lts_pkg.sv
rtl/lts_div.sv
rtl/lts_ctrl.sv
rtl/lts_datapath.sv
rtl/lap_telemetry_statistics_unit.sv
rtl/lts_checker.sv
test/tb_lap_telemetry_statistics_unit.sv
